// File: design/codebook_letter_codec_macros.svh
// ----------------------------------------------------------------------------
// Codebook letter codec assertion macros
// Shared concurrent check forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef CODEBOOK_LETTER_CODEC_MACROS_SVH
`define CODEBOOK_LETTER_CODEC_MACROS_SVH

// same-cycle implication
`define CBL_ASSERT_NOW(name, rstn, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbl same-cycle check failed");

// next-cycle implication
`define CBL_ASSERT_NXT(name, rstn, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbl next-cycle check failed");

`endif

// File: design/cbl_pkg.sv
// ----------------------------------------------------------------------------
// Codebook letter codec package
// Field widths, operation and register codes, character constants, token type.
// ----------------------------------------------------------------------------
package cbl_pkg;

    localparam int DEF_TABLE_ENTRIES    = 32;
    localparam int DEF_MAX_CODE_LETTERS = 10;

    localparam int CHAR_W    = 8;
    localparam int LETTER_W  = 5;
    localparam int IDX_W     = 5;
    localparam int ELEN_W    = 4;
    localparam int ECODE_W   = 50;
    localparam int OP_W      = 2;
    localparam int EIU_W     = 6;
    localparam int S_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd1;

    localparam int CHAR_A_LO   = 97;
    localparam int CHAR_Z_LO   = 122;
    localparam int CHAR_A_UP   = 65;
    localparam int CHAR_Z_UP   = 90;
    localparam int CASE_OFFSET = 32;

    // search token control travelling down the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } cbl_tok_t;

endpackage

// File: design/cbl_cell.sv
// ----------------------------------------------------------------------------
// Codebook cell
// Holds one codebook entry and checks the passing search token against it.
// ----------------------------------------------------------------------------
module cbl_cell #(
    parameter int CELL_IDX         = 0,
    parameter int MAX_CODE_LETTERS = cbl_pkg::DEF_MAX_CODE_LETTERS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // entry load broadcast
    input  logic                                          load_en,
    input  logic [cbl_pkg::IDX_W-1:0]                     load_idx,
    input  logic [cbl_pkg::LETTER_W-1:0]                  load_letter,
    input  logic [$clog2(MAX_CODE_LETTERS+1)-1:0]         load_len,
    input  logic [cbl_pkg::LETTER_W*MAX_CODE_LETTERS-1:0] load_code,
    // search key broadcast
    input  logic                                          key_decode,
    input  logic [cbl_pkg::LETTER_W-1:0]                  key_letter,
    input  logic [$clog2(MAX_CODE_LETTERS+1)-1:0]         key_len,
    input  logic [cbl_pkg::LETTER_W*MAX_CODE_LETTERS-1:0] key_code,
    input  logic [cbl_pkg::EIU_W-1:0]                     entries_in_use,
    // token from the left neighbor
    input  cbl_pkg::cbl_tok_t                             tok_in,
    input  logic [cbl_pkg::LETTER_W-1:0]                  res_letter_in,
    input  logic [$clog2(MAX_CODE_LETTERS+1)-1:0]         res_len_in,
    input  logic [cbl_pkg::LETTER_W*MAX_CODE_LETTERS-1:0] res_code_in,
    // token to the right neighbor
    output cbl_pkg::cbl_tok_t                             tok_out,
    output logic [cbl_pkg::LETTER_W-1:0]                  res_letter_out,
    output logic [$clog2(MAX_CODE_LETTERS+1)-1:0]         res_len_out,
    output logic [cbl_pkg::LETTER_W*MAX_CODE_LETTERS-1:0] res_code_out
);
    import cbl_pkg::*;

    localparam int KEY_W = LETTER_W * MAX_CODE_LETTERS;
    localparam int LEN_W = $clog2(MAX_CODE_LETTERS + 1);

    logic [LETTER_W-1:0] letter_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [KEY_W-1:0]    code_reg;

    cbl_tok_t            tok_reg;
    logic [LETTER_W-1:0] res_letter_reg;
    logic [LEN_W-1:0]    res_len_reg;
    logic [KEY_W-1:0]    res_code_reg;

    logic in_use;
    logic hit;
    logic take;

    assign in_use = (7'(CELL_IDX) < {1'b0, entries_in_use});
    // codes are stored masked to their length, so a decode match is plain equality
    assign hit    = in_use && (key_decode ? ((len_reg == key_len) && (code_reg == key_code))
                                          : (letter_reg == key_letter));
    assign take   = tok_in.valid && !tok_in.found && hit;

    always_ff @(posedge aclk) begin
        if (load_en && ({1'b0, load_idx} == 6'(CELL_IDX))) begin
            letter_reg <= load_letter;
            len_reg    <= load_len;
            code_reg   <= load_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg.valid <= tok_in.valid;
            tok_reg.found <= tok_in.found || take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_letter_reg <= letter_reg;
            res_len_reg    <= len_reg;
            res_code_reg   <= code_reg;
        end else begin
            res_letter_reg <= res_letter_in;
            res_len_reg    <= res_len_in;
            res_code_reg   <= res_code_in;
        end
    end

    assign tok_out        = tok_reg;
    assign res_letter_out = res_letter_reg;
    assign res_len_out    = res_len_reg;
    assign res_code_out   = res_code_reg;

endmodule

// File: design/codebook_letter_codec.sv
// Timing: loads, end of message, pass-through and rejecting letters register their result
//   at the accepting edge; a searching letter launches a token that walks the cell row, one
//   cell per cycle, then its results leave through the emit state, one per cycle unless stalled.
// Throughput: one request at a time; non-searching requests every cycle while the output is
//   not stalled, a searching letter only after its search and its results are done.
// Reset: sync active-low aresetn clears mode, count, partial code, reject flag, handshake.
// ----------------------------------------------------------------------------
// Codebook letter codec
// Letter substitution with a loaded codebook of variable length codes,
// built as a row of entry cells that a search token walks through.
// ----------------------------------------------------------------------------
`include "codebook_letter_codec_macros.svh"

module codebook_letter_codec #(
    parameter int TABLE_ENTRIES    = cbl_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_LETTERS = cbl_pkg::DEF_MAX_CODE_LETTERS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] char_in, [12:8] entry_index, [17:13] entry_letter,
    // [21:18] entry_code_length, [71:22] entry_code
    input  logic [cbl_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  logic [cbl_pkg::OP_W-1:0]         s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] char_out
    output logic [cbl_pkg::CHAR_W-1:0]       m_tdata,
    // [0] char_valid, [1] bad_message
    output logic [cbl_pkg::M_TUSER_W-1:0]    m_tuser,
    // last_of_run
    output logic                             m_tlast,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbl_pkg::*;

    localparam int KEY_W = LETTER_W * MAX_CODE_LETTERS;
    localparam int LEN_W = $clog2(MAX_CODE_LETTERS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    // ---------------- input field split ----------------
    logic [CHAR_W-1:0]   in_char;
    logic [IDX_W-1:0]    in_idx;
    logic [LETTER_W-1:0] in_letter;
    logic [ELEN_W-1:0]   in_len;
    logic [ECODE_W-1:0]  in_code;

    assign in_char   = s_tdata[7:0];
    assign in_idx    = s_tdata[12:8];
    assign in_letter = s_tdata[17:13];
    assign in_len    = s_tdata[21:18];
    assign in_code   = s_tdata[71:22];

    // ---------------- registers ----------------
    logic [1:0]          state_reg, state_next;
    logic                mode_reg;
    logic [EIU_W-1:0]    eiu_reg;
    logic [KEY_W-1:0]    partial_code_reg, partial_code_next;
    logic [LEN_W-1:0]    partial_len_reg, partial_len_next;
    logic                rejected_reg, rejected_next;
    logic                launch_reg, launch_next;
    logic [CHAR_W-1:0]   char_reg, char_next;

    logic                emit_lit_reg, emit_lit_next;
    logic [CHAR_W-1:0]   emit_char_reg, emit_char_next;
    logic [KEY_W-1:0]    emit_code_reg, emit_code_next;
    logic [LEN_W-1:0]    emit_cnt_reg, emit_cnt_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_cvalid_reg, m_cvalid_next;
    logic                m_last_reg, m_last_next;
    logic                m_bad_reg, m_bad_next;

    // ---------------- config port ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            eiu_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_DIRECTION) begin
                mode_reg <= cfg_data[0];
            end else if (cfg_index == CFG_ENTRIES) begin
                eiu_reg <= cfg_data;
            end
        end
    end

    // ---------------- load formatting ----------------
    // length saturates to the code capacity, code is widened/trimmed and masked
    logic [KEY_W-1:0] code_ext;
    logic [KEY_W-1:0] load_code;
    logic [LEN_W-1:0] load_len;

    for (genvar g = 0; g < KEY_W; g++) begin : g_code_ext
        if (g < ECODE_W) begin : g_bit
            assign code_ext[g] = in_code[g];
        end else begin : g_zero
            assign code_ext[g] = 1'b0;
        end
    end

    assign load_len = (in_len > 4'(MAX_CODE_LETTERS)) ? LEN_W'(MAX_CODE_LETTERS)
                                                      : LEN_W'(in_len);

    always_comb begin
        for (int j = 0; j < MAX_CODE_LETTERS; j++) begin
            load_code[j*LETTER_W +: LETTER_W] =
                (LEN_W'(j) < load_len) ? code_ext[j*LETTER_W +: LETTER_W] : '0;
        end
    end

    // ---------------- cell row ----------------
    cbl_tok_t            tok     [TABLE_ENTRIES+1];
    logic [LETTER_W-1:0] tok_let [TABLE_ENTRIES+1];
    logic [LEN_W-1:0]    tok_len [TABLE_ENTRIES+1];
    logic [KEY_W-1:0]    tok_code[TABLE_ENTRIES+1];

    logic                s_accept;
    logic                load_en;
    logic [LETTER_W-1:0] key_letter;

    assign s_accept   = s_tvalid && s_tready;
    assign load_en    = s_accept && (s_tuser == OP_LOAD);
    assign key_letter = LETTER_W'(char_reg - CHAR_W'(CHAR_A_LO));

    assign tok[0].valid = launch_reg;
    assign tok[0].found = 1'b0;
    assign tok_let[0]   = '0;
    assign tok_len[0]   = '0;
    assign tok_code[0]  = '0;

    for (genvar c = 0; c < TABLE_ENTRIES; c++) begin : g_cell
        cbl_cell #(
            .CELL_IDX         (c),
            .MAX_CODE_LETTERS (MAX_CODE_LETTERS)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .load_en        (load_en),
            .load_idx       (in_idx),
            .load_letter    (in_letter),
            .load_len       (load_len),
            .load_code      (load_code),
            .key_decode     (mode_reg),
            .key_letter     (key_letter),
            .key_len        (partial_len_reg),
            .key_code       (partial_code_reg),
            .entries_in_use (eiu_reg),
            .tok_in         (tok[c]),
            .res_letter_in  (tok_let[c]),
            .res_len_in     (tok_len[c]),
            .res_code_in    (tok_code[c]),
            .tok_out        (tok[c+1]),
            .res_letter_out (tok_let[c+1]),
            .res_len_out    (tok_len[c+1]),
            .res_code_out   (tok_code[c+1])
        );
    end

    cbl_tok_t tail;
    assign tail = tok[TABLE_ENTRIES];

    // ---------------- character classification ----------------
    logic              is_upper;
    logic [CHAR_W-1:0] ch_fold;
    logic              is_letter;
    logic [KEY_W-1:0]  partial_ins;

    assign is_upper  = (in_char >= 8'(CHAR_A_UP)) && (in_char <= 8'(CHAR_Z_UP));
    assign ch_fold   = is_upper ? (in_char + 8'(CASE_OFFSET)) : in_char;
    assign is_letter = (ch_fold >= 8'(CHAR_A_LO)) && (ch_fold <= 8'(CHAR_Z_LO));

    // new letter dropped into the slot after the pending ones
    always_comb begin
        for (int j = 0; j < MAX_CODE_LETTERS; j++) begin
            partial_ins[j*LETTER_W +: LETTER_W] =
                (LEN_W'(j) == partial_len_reg) ? LETTER_W'(ch_fold - 8'(CHAR_A_LO))
                                               : partial_code_reg[j*LETTER_W +: LETTER_W];
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;

    // ---------------- control ----------------
    always_comb begin
        state_next        = state_reg;
        partial_code_next = partial_code_reg;
        partial_len_next  = partial_len_reg;
        rejected_next     = rejected_reg;
        launch_next       = 1'b0;
        char_next         = char_reg;
        emit_lit_next     = emit_lit_reg;
        emit_char_next    = emit_char_reg;
        emit_code_next    = emit_code_reg;
        emit_cnt_next     = emit_cnt_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_cvalid_next = m_cvalid_reg;
        m_last_next   = m_last_reg;
        m_bad_next    = m_bad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_END) begin
                        m_tvalid_next     = 1'b1;
                        m_char_next       = '0;
                        m_cvalid_next     = 1'b0;
                        m_last_next       = 1'b1;
                        m_bad_next        = rejected_reg ||
                                            (mode_reg && (partial_len_reg != '0));
                        partial_code_next = '0;
                        partial_len_next  = '0;
                        rejected_next     = 1'b0;
                    end else if ((s_tuser == OP_CHAR) && !rejected_reg) begin
                        char_next = ch_fold;
                        if (!is_letter) begin
                            // pass-through in either mode
                            m_tvalid_next = 1'b1;
                            m_char_next   = ch_fold;
                            m_cvalid_next = 1'b1;
                            m_last_next   = 1'b1;
                            m_bad_next    = 1'b0;
                        end else if (!mode_reg) begin
                            launch_next = 1'b1;
                            state_next  = ST_SEARCH;
                        end else if (partial_len_reg >= LEN_W'(MAX_CODE_LETTERS)) begin
                            // code too long: reject rest of message
                            rejected_next     = 1'b1;
                            partial_code_next = '0;
                            partial_len_next  = '0;
                            m_tvalid_next     = 1'b1;
                            m_char_next       = '0;
                            m_cvalid_next     = 1'b0;
                            m_last_next       = 1'b1;
                            m_bad_next        = 1'b1;
                        end else begin
                            partial_code_next = partial_ins;
                            partial_len_next  = partial_len_reg + 1'b1;
                            launch_next       = 1'b1;
                            state_next        = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (tail.valid) begin
                    if (mode_reg) begin
                        if (tail.found) begin
                            partial_code_next = '0;
                            partial_len_next  = '0;
                            emit_lit_next     = 1'b1;
                            emit_char_next    = 8'(CHAR_A_LO) + CHAR_W'(tok_let[TABLE_ENTRIES]);
                            state_next        = ST_EMIT;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else if (tail.found) begin
                        emit_lit_next  = 1'b0;
                        emit_code_next = tok_code[TABLE_ENTRIES];
                        emit_cnt_next  = tok_len[TABLE_ENTRIES];
                        // empty code emits nothing
                        state_next     = (tok_len[TABLE_ENTRIES] == '0) ? ST_IDLE : ST_EMIT;
                    end else begin
                        emit_lit_next  = 1'b1;
                        emit_char_next = char_reg;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_cvalid_next = 1'b1;
                    m_bad_next    = 1'b0;
                    if (emit_lit_reg) begin
                        m_char_next = emit_char_reg;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        m_char_next    = 8'(CHAR_A_LO) + CHAR_W'(emit_code_reg[LETTER_W-1:0]);
                        m_last_next    = (emit_cnt_reg == LEN_W'(1));
                        emit_code_next = emit_code_reg >> LETTER_W;
                        emit_cnt_next  = emit_cnt_reg - 1'b1;
                        if (emit_cnt_reg == LEN_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            partial_code_reg <= '0;
            partial_len_reg  <= '0;
            rejected_reg     <= 1'b0;
            launch_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            partial_code_reg <= partial_code_next;
            partial_len_reg  <= partial_len_next;
            rejected_reg     <= rejected_next;
            launch_reg       <= launch_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        emit_lit_reg  <= emit_lit_next;
        emit_char_reg <= emit_char_next;
        emit_code_reg <= emit_code_next;
        emit_cnt_reg  <= emit_cnt_next;
        m_char_reg    <= m_char_next;
        m_cvalid_reg  <= m_cvalid_next;
        m_last_reg    <= m_last_next;
        m_bad_reg     <= m_bad_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = {m_bad_reg, m_cvalid_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- checks ----------------
    `CBL_ASSERT_NOW(a_tail_in_search, aresetn, tail.valid, state_reg == ST_SEARCH)
    `CBL_ASSERT_NXT(a_launch_holds_search, aresetn, launch_reg, state_reg == ST_SEARCH)
    `CBL_ASSERT_NOW(a_partial_bound, aresetn, 1'b1, partial_len_reg <= LEN_W'(MAX_CODE_LETTERS))
    `CBL_ASSERT_NOW(a_reject_clears, aresetn, rejected_reg, partial_len_reg == '0)
    `CBL_ASSERT_NOW(a_emit_count, aresetn, (state_reg == ST_EMIT) && !emit_lit_reg, emit_cnt_reg != '0)

endmodule
